[rtl/core/ipts_pkg.sv]
// Shared types and codes for the I2C packet transaction sequencer.
package ipts_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OFF_W  = 5;

  typedef enum logic [2:0] {
    OP_SEND        = 3'd0,
    OP_TX_DONE     = 3'd1,
    OP_RX_DONE     = 3'd2,
    OP_BUS_ERROR   = 3'd3,
    OP_ABORT_DONE  = 3'd4,
    OP_CLEAR_READY = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TX1   = 3'd1,
    PH_TX2   = 3'd2,
    PH_TXR1  = 3'd3,
    PH_TXR2  = 3'd4,
    PH_RX1   = 3'd5,
    PH_RX2   = 3'd6,
    PH_ABORT = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_TX    = 2'd1,
    KIND_RX    = 2'd2,
    KIND_ABORT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FRAME_FIRST       = 2'd0,
    FRAME_LAST        = 2'd1,
    FRAME_LAST_NOSTOP = 2'd2
  } frame_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] dev_address;
    logic              needs_response;
    logic [BYTE_W-1:0] packet_len;
    logic [BYTE_W-1:0] rx_len_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]        cmd_kind;
    logic [BYTE_W-1:0] cmd_address;
    logic [OFF_W-1:0]  cmd_offset;
    logic [BYTE_W-1:0] cmd_count;
    logic [1:0]        cmd_frame;
    logic              busy_res;
    logic [BYTE_W-1:0] ready_len;
  } res_t;

endpackage

[rtl/core/ipts_seq.sv]
// Transaction phase register and per-request command decode.
module ipts_seq import ipts_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  req_t req,
  output res_t res
);

  localparam logic [OFF_W-1:0]  HdrOff  = OFF_W'(HEADER_BYTES);
  localparam logic [BYTE_W-1:0] HdrCnt  = BYTE_W'(HEADER_BYTES);
  localparam logic [BYTE_W:0]   HdrWide = (BYTE_W+1)'(HEADER_BYTES);

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] addr_r, addr_nxt;
  logic [BYTE_W-1:0] flen_r, flen_nxt;
  logic              rdy_r, rdy_nxt;

  logic [BYTE_W-1:0] body_cnt;
  logic [BYTE_W:0]   rx_sum;
  kind_t             kind;
  logic [OFF_W-1:0]  offset;
  logic [BYTE_W-1:0] count;
  frame_t            frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      addr_r  <= '0;
      flen_r  <= '0;
      rdy_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      flen_r  <= flen_nxt;
      rdy_r   <= rdy_nxt;
    end
  end

  always_comb begin
    body_cnt  = (flen_r > HdrCnt) ? (flen_r - HdrCnt) : '0;
    rx_sum    = {1'b0, req.rx_len_byte} + HdrWide;
    phase_nxt = phase_r;
    addr_nxt  = addr_r;
    flen_nxt  = flen_r;
    rdy_nxt   = rdy_r;
    kind      = KIND_NONE;
    offset    = '0;
    count     = '0;
    frame     = FRAME_FIRST;
    unique case (op_t'(req.operation))
      OP_SEND: begin
        if (phase_r == PH_IDLE) begin
          rdy_nxt   = 1'b0;
          addr_nxt  = req.dev_address;
          flen_nxt  = req.packet_len;
          phase_nxt = req.needs_response ? PH_TXR1 : PH_TX1;
          kind      = KIND_TX;
          count     = HdrCnt;
        end else if (phase_r != PH_ABORT) begin
          phase_nxt = PH_ABORT;
          kind      = KIND_ABORT;
        end
      end
      OP_TX_DONE: begin
        unique case (phase_r)
          PH_TX1: begin
            phase_nxt = PH_TX2;
            kind      = KIND_TX;
            offset    = HdrOff;
            count     = body_cnt;
            frame     = FRAME_LAST;
          end
          PH_TXR1: begin
            phase_nxt = PH_TXR2;
            kind      = KIND_TX;
            offset    = HdrOff;
            count     = body_cnt;
            frame     = FRAME_LAST_NOSTOP;
          end
          PH_TXR2: begin
            phase_nxt = PH_RX1;
            kind      = KIND_RX;
            count     = HdrCnt;
          end
          PH_TX2, PH_ABORT: phase_nxt = PH_IDLE;
          default: ;
        endcase
      end
      OP_RX_DONE: begin
        unique case (phase_r)
          PH_RX1: begin
            phase_nxt = PH_RX2;
            flen_nxt  = rx_sum[BYTE_W] ? '1 : rx_sum[BYTE_W-1:0];
            kind      = KIND_RX;
            offset    = HdrOff;
            count     = req.rx_len_byte;
            frame     = FRAME_LAST;
          end
          PH_RX2: begin
            phase_nxt = PH_IDLE;
            rdy_nxt   = 1'b1;
          end
          PH_ABORT: phase_nxt = PH_IDLE;
          default: ;
        endcase
      end
      OP_BUS_ERROR: begin
        phase_nxt = PH_ABORT;
        kind      = KIND_ABORT;
      end
      OP_ABORT_DONE: begin
        if (phase_r == PH_ABORT) begin
          phase_nxt = PH_IDLE;
        end
      end
      OP_CLEAR_READY: rdy_nxt = 1'b0;
      default: ;
    endcase

    res.cmd_kind    = kind;
    res.cmd_address = (kind == KIND_NONE) ? '0 : addr_nxt;
    res.cmd_offset  = offset;
    res.cmd_count   = count;
    res.cmd_frame   = frame;
    res.busy_res    = (phase_nxt != PH_IDLE);
    res.ready_len   = rdy_nxt ? flen_nxt : '0;
  end

endmodule

[rtl/core/ipts_oreg.sv]
// Result register with valid/ready hand-off.
module ipts_oreg import ipts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t d,
  input  logic out_ready,
  output logic can_load,
  output logic out_valid,
  output res_t q
);

  logic valid_r, valid_nxt;
  res_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= d;
    end
  end

  assign out_valid = valid_r;
  assign q         = data_r;

endmodule

[rtl/core/i2c_packet_transaction_sequencer_unit.sv]
// Top level of the I2C packet transaction sequencer.
//
//   channel   direction  handshake              payload
//   in_       input      in_valid / in_ready    operation, address, response, lengths
//   out_      output     out_valid / out_ready  command, busy flag, ready length
//
// One request per cycle sustained while out_ready is high; a taken request is registered
// in the input register, then its result in the result register.
// The phase register updates when a request moves from the input register to the result register.
// rst_n is synchronous: phase idle, address, length and ready flag cleared, both stages empty.
// A stalled result holds the result register, and the input register then holds one more request.
module i2c_packet_transaction_sequencer_unit import ipts_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [BYTE_W-1:0] in_dev_address,
  input  logic              in_needs_response,
  input  logic [BYTE_W-1:0] in_packet_len,
  input  logic [BYTE_W-1:0] in_rx_len_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_cmd_kind,
  output logic [BYTE_W-1:0] out_cmd_address,
  output logic [OFF_W-1:0]  out_cmd_offset,
  output logic [BYTE_W-1:0] out_cmd_count,
  output logic [1:0]        out_cmd_frame,
  output logic              out_busy_res,
  output logic [BYTE_W-1:0] out_ready_len
);

  logic in_valid_r, in_valid_nxt;
  req_t req_r;
  logic can_load;
  logic fire;
  res_t res;
  res_t res_q;

  assign fire         = in_valid_r && can_load;
  assign in_ready     = !in_valid_r || can_load;
  assign in_valid_nxt = in_ready ? in_valid : in_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.operation      <= in_operation;
      req_r.dev_address    <= in_dev_address;
      req_r.needs_response <= in_needs_response;
      req_r.packet_len     <= in_packet_len;
      req_r.rx_len_byte    <= in_rx_len_byte;
    end
  end

  ipts_seq #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .req  (req_r),
    .res  (res)
  );

  ipts_oreg u_oreg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire),
    .d        (res),
    .out_ready(out_ready),
    .can_load (can_load),
    .out_valid(out_valid),
    .q        (res_q)
  );

  assign out_cmd_kind    = res_q.cmd_kind;
  assign out_cmd_address = res_q.cmd_address;
  assign out_cmd_offset  = res_q.cmd_offset;
  assign out_cmd_count   = res_q.cmd_count;
  assign out_cmd_frame   = res_q.cmd_frame;
  assign out_busy_res    = res_q.busy_res;
  assign out_ready_len   = res_q.ready_len;

endmodule

[rtl/core/ipts_checker.sv]
// Port-level checks for the I2C packet transaction sequencer, bound to the top level.
module ipts_checker import ipts_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 4
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_cmd_kind,
  input logic [BYTE_W-1:0] out_cmd_address,
  input logic [OFF_W-1:0]  out_cmd_offset,
  input logic [BYTE_W-1:0] out_cmd_count,
  input logic [1:0]        out_cmd_frame,
  input logic              out_busy_res
);

  localparam logic [BYTE_W-1:0] HdrCnt = BYTE_W'(HEADER_BYTES);

  logic [1:0] kind_none;
  logic [1:0] kind_abort;
  logic [1:0] frame_first;

  assign kind_none   = KIND_NONE;
  assign kind_abort  = KIND_ABORT;
  assign frame_first = FRAME_FIRST;

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cmd_kind)
      && $stable(out_cmd_address) && $stable(out_cmd_count) && $stable(out_busy_res))
    else $error("stalled result changed");

  a_no_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cmd_kind == kind_none |-> out_cmd_address == '0
      && out_cmd_offset == '0 && out_cmd_count == '0 && out_cmd_frame == frame_first)
    else $error("empty command carries fields");

  a_abort_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cmd_kind == kind_abort |-> out_busy_res && out_cmd_offset == '0
      && out_cmd_count == '0 && out_cmd_frame == frame_first)
    else $error("abort command malformed");

  a_header_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cmd_kind != kind_none && out_cmd_kind != kind_abort
      && out_cmd_frame == frame_first
      |-> out_busy_res && out_cmd_offset == '0 && out_cmd_count == HdrCnt)
    else $error("header command malformed");

endmodule

bind i2c_packet_transaction_sequencer_unit ipts_checker #(
  .HEADER_BYTES(HEADER_BYTES)
) u_ipts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_cmd_kind   (out_cmd_kind),
  .out_cmd_address(out_cmd_address),
  .out_cmd_offset (out_cmd_offset),
  .out_cmd_count  (out_cmd_count),
  .out_cmd_frame  (out_cmd_frame),
  .out_busy_res   (out_busy_res)
);

[sim/tb_top.sv]
// Self-checking testbench for the I2C packet transaction sequencer unit.
`timescale 1ns / 1ps

module tb_top import ipts_pkg::*;;

  localparam int unsigned HDR_BYTES = 4;
  localparam logic [OFF_W-1:0]  HDR_OFF  = OFF_W'(HDR_BYTES);
  localparam logic [BYTE_W-1:0] HDR_CNT  = BYTE_W'(HDR_BYTES);
  localparam logic [BYTE_W:0]   HDR_WIDE = (BYTE_W+1)'(HDR_BYTES);
  localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;
  localparam int unsigned ITEMS_PER_PHASE = 235;

  class cmd_tracker;
    phase_t            phase      = PH_IDLE;
    logic [BYTE_W-1:0] tgt_addr   = '0;
    logic [BYTE_W-1:0] frame_len  = '0;
    logic              data_ready = 1'b0;
    res_t              pending_cmds[$];
    int unsigned       errors     = 0;

    function res_t issue(kind_t k, logic [OFF_W-1:0] off, logic [BYTE_W-1:0] cnt,
                         frame_t fr);
      res_t c;
      c = '0;
      c.cmd_kind    = k;
      c.cmd_address = (k == KIND_NONE) ? '0 : tgt_addr;
      c.cmd_offset  = off;
      c.cmd_count   = cnt;
      c.cmd_frame   = fr;
      return c;
    endfunction

    function logic [BYTE_W-1:0] body_count();
      return (frame_len > HDR_CNT) ? frame_len - HDR_CNT : '0;
    endfunction

    function void take_request(req_t r);
      res_t       c;
      logic [8:0] sum;
      c = issue(KIND_NONE, '0, '0, FRAME_FIRST);
      case (r.operation)
        OP_SEND: begin
          if (phase == PH_IDLE) begin
            data_ready = 1'b0;
            tgt_addr   = r.dev_address;
            frame_len  = r.packet_len;
            phase      = r.needs_response ? PH_TXR1 : PH_TX1;
            c = issue(KIND_TX, '0, HDR_CNT, FRAME_FIRST);
          end else if (phase != PH_ABORT) begin
            phase = PH_ABORT;
            c = issue(KIND_ABORT, '0, '0, FRAME_FIRST);
          end
        end
        OP_TX_DONE: begin
          case (phase)
            PH_TX1: begin
              phase = PH_TX2;
              c = issue(KIND_TX, HDR_OFF, body_count(), FRAME_LAST);
            end
            PH_TXR1: begin
              phase = PH_TXR2;
              c = issue(KIND_TX, HDR_OFF, body_count(), FRAME_LAST_NOSTOP);
            end
            PH_TXR2: begin
              phase = PH_RX1;
              c = issue(KIND_RX, '0, HDR_CNT, FRAME_FIRST);
            end
            PH_TX2, PH_ABORT: phase = PH_IDLE;
            default: ;
          endcase
        end
        OP_RX_DONE: begin
          if (phase == PH_RX1) begin
            phase     = PH_RX2;
            sum       = {1'b0, r.rx_len_byte} + HDR_WIDE;
            frame_len = sum[8] ? 8'hFF : sum[7:0];
            c = issue(KIND_RX, HDR_OFF, r.rx_len_byte, FRAME_LAST);
          end else if (phase == PH_RX2) begin
            phase      = PH_IDLE;
            data_ready = 1'b1;
          end else if (phase == PH_ABORT) begin
            phase = PH_IDLE;
          end
        end
        OP_BUS_ERROR: begin
          phase = PH_ABORT;
          c = issue(KIND_ABORT, '0, '0, FRAME_FIRST);
        end
        OP_ABORT_DONE: if (phase == PH_ABORT) phase = PH_IDLE;
        OP_CLEAR_READY: data_ready = 1'b0;
        default: ;
      endcase
      c.busy_res  = (phase != PH_IDLE);
      c.ready_len = data_ready ? frame_len : '0;
      pending_cmds.push_back(c);
    endfunction

    function void cmp_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending_cmds.size() == 0) begin
        $error("result with no request pending: kind %0d", got.cmd_kind);
        errors++;
        return;
      end
      e = pending_cmds.pop_front();
      cmp_field("cmd_kind", e.cmd_kind, got.cmd_kind);
      cmp_field("cmd_address", e.cmd_address, got.cmd_address);
      cmp_field("cmd_offset", e.cmd_offset, got.cmd_offset);
      cmp_field("cmd_count", e.cmd_count, got.cmd_count);
      cmp_field("cmd_frame", e.cmd_frame, got.cmd_frame);
      cmp_field("busy_res", e.busy_res, got.busy_res);
      cmp_field("ready_len", e.ready_len, got.ready_len);
    endfunction

    function int unsigned pending();
      return pending_cmds.size();
    endfunction
  endclass

  logic              clk               = 1'b0;
  logic              rst_n             = 1'b0;
  logic              in_valid          = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_operation      = '0;
  logic [BYTE_W-1:0] in_dev_address    = '0;
  logic              in_needs_response = 1'b0;
  logic [BYTE_W-1:0] in_packet_len     = '0;
  logic [BYTE_W-1:0] in_rx_len_byte    = '0;
  logic              out_valid;
  logic              out_ready         = 1'b0;
  logic [1:0]        out_cmd_kind;
  logic [BYTE_W-1:0] out_cmd_address;
  logic [OFF_W-1:0]  out_cmd_offset;
  logic [BYTE_W-1:0] out_cmd_count;
  logic [1:0]        out_cmd_frame;
  logic              out_busy_res;
  logic [BYTE_W-1:0] out_ready_len;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  cmd_tracker  sb;
  req_t        directed_q[$];

  i2c_packet_transaction_sequencer_unit #(.HEADER_BYTES(HDR_BYTES)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_dev_address    (in_dev_address),
    .in_needs_response (in_needs_response),
    .in_packet_len     (in_packet_len),
    .in_rx_len_byte    (in_rx_len_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cmd_kind      (out_cmd_kind),
    .out_cmd_address   (out_cmd_address),
    .out_cmd_offset    (out_cmd_offset),
    .out_cmd_count     (out_cmd_count),
    .out_cmd_frame     (out_cmd_frame),
    .out_busy_res      (out_busy_res),
    .out_ready_len     (out_ready_len)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result({out_cmd_kind, out_cmd_address, out_cmd_offset, out_cmd_count,
                       out_cmd_frame, out_busy_res, out_ready_len});
    end
  end

  function automatic req_t mk(logic [OP_W-1:0] op, logic [BYTE_W-1:0] addr, logic resp,
                              logic [BYTE_W-1:0] plen, logic [BYTE_W-1:0] rlen);
    req_t r;
    r.operation      = op;
    r.dev_address    = addr;
    r.needs_response = resp;
    r.packet_len     = plen;
    r.rx_len_byte    = rlen;
    return r;
  endfunction

  // Favour the event that fits the current phase; the rest is noise.
  function automatic req_t random_req(phase_t ph);
    req_t r;
    r.dev_address    = BYTE_W'($urandom);
    r.needs_response = 1'($urandom);
    r.packet_len     = ($urandom_range(3) == 0) ? BYTE_W'($urandom)
                                                : BYTE_W'($urandom_range(8));
    r.rx_len_byte    = ($urandom_range(3) == 0) ? BYTE_W'($urandom_range(248, 255))
                                                : BYTE_W'($urandom);
    if ($urandom_range(99) < 85) begin
      case (ph)
        PH_IDLE: r.operation = ($urandom_range(9) == 0) ? OP_CLEAR_READY : OP_SEND;
        PH_TX1, PH_TX2, PH_TXR1, PH_TXR2: r.operation = OP_TX_DONE;
        PH_RX1, PH_RX2: r.operation = OP_RX_DONE;
        default: begin
          case ($urandom_range(3))
            0: r.operation = OP_ABORT_DONE;
            1: r.operation = OP_TX_DONE;
            2: r.operation = OP_RX_DONE;
            default: r.operation = OP_SEND;
          endcase
        end
      endcase
    end else begin
      r.operation = OP_W'($urandom_range(7));
    end
    return r;
  endfunction

  task automatic push_req(req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_operation      <= r.operation;
    in_dev_address    <= r.dev_address;
    in_needs_response <= r.needs_response;
    in_packet_len     <= r.packet_len;
    in_rx_len_byte    <= r.rx_len_byte;
    do @(posedge clk); while (!in_ready);
    sb.take_request(r);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (ITEMS_PER_PHASE) push_req(random_req(sb.phase));
    drain();
  endtask

  initial begin
    sb = new;
    directed_q.push_back(mk(OP_SEND, 8'hFF, 1'b0, 8'hFF, 8'h00));
    directed_q.push_back(mk(OP_TX_DONE, 8'h00, 1'b0, 8'h00, 8'h00));
    directed_q.push_back(mk(OP_TX_DONE, 8'h00, 1'b0, 8'h00, 8'h00));
    directed_q.push_back(mk(OP_TX_DONE, 8'hFF, 1'b1, 8'hFF, 8'hFF));
    directed_q.push_back(mk(OP_ABORT_DONE, 8'h00, 1'b0, 8'h00, 8'h00));
    directed_q.push_back(mk(OP_SEND, 8'h00, 1'b1, 8'h00, 8'h00));
    directed_q.push_back(mk(OP_TX_DONE, 8'h00, 1'b0, 8'h00, 8'h00));
    directed_q.push_back(mk(OP_RX_DONE, 8'h00, 1'b0, 8'h00, 8'h33));
    directed_q.push_back(mk(OP_TX_DONE, 8'h00, 1'b0, 8'h00, 8'h00));
    directed_q.push_back(mk(OP_RX_DONE, 8'h00, 1'b0, 8'h00, 8'hFF));
    directed_q.push_back(mk(OP_RX_DONE, 8'h00, 1'b0, 8'h00, 8'h00));
    directed_q.push_back(mk(OP_CLEAR_READY, 8'h00, 1'b0, 8'h00, 8'h00));
    directed_q.push_back(mk(OP_SEND, 8'hA5, 1'b1, 8'h04, 8'h00));
    directed_q.push_back(mk(OP_TX_DONE, 8'h00, 1'b0, 8'h00, 8'h00));
    directed_q.push_back(mk(OP_TX_DONE, 8'h00, 1'b0, 8'h00, 8'h00));
    directed_q.push_back(mk(OP_RX_DONE, 8'h00, 1'b0, 8'h00, 8'h00));
    directed_q.push_back(mk(OP_RX_DONE, 8'h00, 1'b0, 8'h00, 8'h00));
    directed_q.push_back(mk(OP_SEND, 8'h5A, 1'b0, 8'h55, 8'h00));
    directed_q.push_back(mk(OP_SEND, 8'h11, 1'b1, 8'h22, 8'h00));
    directed_q.push_back(mk(OP_SEND, 8'h33, 1'b0, 8'h44, 8'h00));
    directed_q.push_back(mk(OP_ABORT_DONE, 8'h00, 1'b0, 8'h00, 8'h00));
    directed_q.push_back(mk(OP_BUS_ERROR, 8'h00, 1'b0, 8'h00, 8'h00));
    directed_q.push_back(mk(OP_TX_DONE, 8'h00, 1'b0, 8'h00, 8'h00));
    directed_q.push_back(mk(OP_BUS_ERROR, 8'h00, 1'b0, 8'h00, 8'h00));
    directed_q.push_back(mk(OP_RX_DONE, 8'h00, 1'b0, 8'h00, 8'h00));
    directed_q.push_back(mk(OP_UNUSED_A, 8'hFF, 1'b1, 8'hFF, 8'hFF));
    directed_q.push_back(mk(OP_UNUSED_B, 8'hFF, 1'b1, 8'hFF, 8'hFF));

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_q[i]) push_req(directed_q[i]);
    drain();

    run_phase(0, 0);
    run_phase(70, 0);
    run_phase(0, 70);
    run_phase(12, 12);

    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
rtl/core/ipts_pkg.sv
rtl/core/ipts_seq.sv
rtl/core/ipts_oreg.sv
rtl/core/i2c_packet_transaction_sequencer_unit.sv
rtl/core/ipts_checker.sv
sim/tb_top.sv
